// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked at every clock edge out of reset
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ksd_pkg.sv =====
// ----------------------------------------------------------------------------
// ksd_pkg
// constants and helpers for the keyed seed derivation block
// ----------------------------------------------------------------------------
package ksd_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 8;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // fnv-1a 32
    localparam word_t FNV_BASIS  = 32'd2166136261;
    localparam word_t FNV_PRIME  = 32'd16777619;

    // seed sequence generate, one output word
    localparam word_t MIX_INIT   = 32'h8b8b8b8b;
    localparam word_t MIX_MUL1   = 32'd1664525;
    localparam word_t MIX_MUL2   = 32'd1566083941;
    localparam word_t MIX_ADD1   = 32'd2;
    localparam word_t MIX_TRIPLE = 32'd3;

    // configuration register indexes
    localparam cfg_idx_t REG_GLOBAL_SEED = 8'd0;
    localparam cfg_idx_t REG_SEED_GIVEN  = 8'd1;

    function automatic word_t temper(input word_t x);
        temper = x ^ (x >> 27);
    endfunction

endpackage

// ===== rtl/keyed_seed_derivation.sv =====
// ----------------------------------------------------------------------------
// keyed_seed_derivation
// fnv-1a 32 key hash mixed with a base seed by the seed sequence generate rule
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one key byte per beat with
//   byte_valid and last. a beat with last set finishes the key and produces
//   one result beat on the output channel (out_valid/out_ready): derived
//   seed, key hash and the unseeded flag. other beats produce nothing.
//   config channel (cfg_valid/cfg_ready) is always ready; index 0 writes
//   the base seed, index 1 writes seed_given, other indexes are dropped.
//   sequence: every input beat is accepted, then makes one pass through the
//   shared 32x32 multiplier (S_HASH). a last beat adds 5 more multiplier
//   passes for the mix (S_MIX1..S_MIX5), then S_DONE loads the output register
//   once it is free; out_valid rises in the same cycle in_ready returns.
//   the single multiply-add unit does all work, one step a cycle outside S_DONE.
//   reset: running hash returns to the fnv offset basis, the base seed and
//   seed_given clear, output is empty.
//   stall: a held result stays in the output register; the block keeps
//   taking beats and only waits if a new result is ready while the old one
//   has not been taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_seed_derivation
    import ksd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,

    input  logic     in_valid,
    output logic     in_ready,
    input  byte_t    key_byte,
    input  logic     byte_valid,
    input  logic     last,

    output logic     out_valid,
    input  logic     out_ready,
    output word_t    derived_seed,
    output word_t    key_hash,
    output logic     unseeded,

    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  cfg_idx_t cfg_index,
    input  word_t    cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HASH = 3'd1;
    localparam logic [2:0] S_MIX1 = 3'd2;
    localparam logic [2:0] S_MIX2 = 3'd3;
    localparam logic [2:0] S_MIX3 = 3'd4;
    localparam logic [2:0] S_MIX4 = 3'd5;
    localparam logic [2:0] S_MIX5 = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] state_reg, state_next;
    word_t      hash_reg, hash_next;
    word_t      acc_reg, acc_next;
    byte_t      byte_reg;
    logic       bvalid_reg;
    logic       last_reg;
    word_t      base_seed_reg;
    logic       seed_given_reg;
    logic       out_valid_reg, out_valid_next;
    word_t      derived_reg;
    word_t      key_hash_reg;
    logic       unseeded_reg;

    logic       in_beat;
    logic       out_free;
    logic       out_load;

    // shared multiply-add unit
    word_t      mul_x;
    word_t      mul_f;
    word_t      mul_add;
    word_t      mul_prod;
    word_t      unit_out;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        mul_x   = acc_reg;
        mul_f   = MIX_TRIPLE;
        mul_add = '0;
        case (state_reg)
            S_HASH:
            begin
                mul_x = hash_reg ^ {{(WORD_W-BYTE_W){1'b0}}, byte_reg};
                mul_f = FNV_PRIME;
            end
            S_MIX1:
            begin
                mul_x   = temper(acc_reg);
                mul_f   = MIX_MUL1;
                mul_add = MIX_ADD1;
            end
            S_MIX2:
            begin
                mul_x   = temper(acc_reg);
                mul_f   = MIX_MUL1;
                mul_add = base_seed_reg;
            end
            S_MIX3:
            begin
                mul_x   = temper(acc_reg);
                mul_f   = MIX_MUL1;
                mul_add = hash_reg;
            end
            S_MIX4:
            begin
                mul_x = acc_reg;
                mul_f = MIX_TRIPLE;
            end
            S_MIX5:
            begin
                mul_x = temper(acc_reg);
                mul_f = MIX_MUL2;
            end
            default:
            begin
                mul_x   = acc_reg;
                mul_f   = MIX_TRIPLE;
                mul_add = '0;
            end
        endcase
    end

    // low half of the product is all that modulo 2^32 needs
    assign mul_prod = word_t'(mul_x * mul_f);
    assign unit_out = mul_prod + mul_add;

    always_comb
    begin
        state_next = state_reg;
        hash_next  = hash_reg;
        acc_next   = acc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (bvalid_reg)
                begin
                    hash_next = unit_out;
                end
                acc_next   = MIX_INIT;
                state_next = last_reg ? S_MIX1 : S_IDLE;
            end
            S_MIX1:
            begin
                acc_next   = unit_out;
                state_next = S_MIX2;
            end
            S_MIX2:
            begin
                acc_next   = unit_out;
                state_next = S_MIX3;
            end
            S_MIX3:
            begin
                acc_next   = unit_out;
                state_next = S_MIX4;
            end
            S_MIX4:
            begin
                acc_next   = unit_out;
                state_next = S_MIX5;
            end
            S_MIX5:
            begin
                acc_next   = unit_out;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    hash_next  = FNV_BASIS;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hash_reg       <= FNV_BASIS;
            base_seed_reg  <= '0;
            seed_given_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GLOBAL_SEED)
                begin
                    base_seed_reg <= cfg_data;
                end
                else if (cfg_index == REG_SEED_GIVEN)
                begin
                    seed_given_reg <= cfg_data[0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (in_beat)
        begin
            byte_reg   <= key_byte;
            bvalid_reg <= byte_valid;
            last_reg   <= last;
        end
        if (out_load)
        begin
            derived_reg  <= acc_reg;
            key_hash_reg <= hash_reg;
            unseeded_reg <= !seed_given_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign derived_seed = derived_reg;
    assign key_hash     = key_hash_reg;
    assign unseeded     = unseeded_reg;

    `ASSERT_IMPL(a_rise_from_done, $rose(out_valid_reg), $past(state_reg) == S_DONE,
        "result appeared without finishing the mix")
    `ASSERT_NEXT(a_hash_cleared, out_load, hash_reg == FNV_BASIS,
        "running hash not returned to offset basis after result")
    `ASSERT_NEXT(a_idle_keeps_hash, (state_reg == S_HASH) && !bvalid_reg, $stable(hash_reg),
        "hash changed on a beat without a key byte")
    `ASSERT_PROP(a_done_only_after_last,
        (state_reg != S_DONE) || last_reg,
        "mix sequence ran for a beat without last")

endmodule
